// ----- sv/rls_pkg.sv -----
`timescale 1ns / 1ps

package rls_pkg;

    // sector geometry
    localparam int SECTOR_BYTES = 4096;
    localparam int OFS_W        = $clog2(SECTOR_BYTES + 1);
    localparam int IDX_W        = 4;
    localparam int OUT_OFS_W    = 13;

    // record layout
    localparam logic [31:0]      REC_MAGIC   = 32'h3153_4652;
    localparam logic [15:0]      REC_VERSION = 16'd1;
    localparam logic [15:0]      REC_SIZE    = 16'd16;
    localparam logic [IDX_W-1:0] HDR_BYTES   = 4'd8;
    localparam logic [IDX_W-1:0] VOL_POS     = 4'd8;
    localparam logic [IDX_W-1:0] THEME_POS   = 4'd9;
    localparam logic [IDX_W-1:0] CRC_BYTES   = 4'd12;
    localparam logic [IDX_W-1:0] LAST_POS    = 4'd15;
    localparam logic [7:0]       VOLUME_MAX  = 8'd100;
    localparam logic [7:0]       ERASED_BYTE = 8'hFF;

    // crc-32, reflected form
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // configuration register map
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_VOLUME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_THEME  = 1'd1;
    localparam logic [6:0] DEFAULT_VOLUME_RST = 7'd50;
    localparam logic [7:0] DEFAULT_THEME_RST  = 8'd0;

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_ERASED  = 2'd1,
        ST_CORRUPT = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // per-record classification, seen with the byte that is being taken
    typedef struct packed {
        logic       last;
        logic       erased;
        logic       good;
        logic [7:0] vol_byte;
        logic [7:0] theme_byte;
    } rec_info_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // expected header bytes 0..7, little-endian fields
    function automatic logic [7:0] header_byte(input logic [2:0] i);
        logic [7:0] v;
        case (i)
            3'd0:    v = REC_MAGIC[7:0];
            3'd1:    v = REC_MAGIC[15:8];
            3'd2:    v = REC_MAGIC[23:16];
            3'd3:    v = REC_MAGIC[31:24];
            3'd4:    v = REC_VERSION[7:0];
            3'd5:    v = REC_VERSION[15:8];
            3'd6:    v = REC_SIZE[7:0];
            default: v = REC_SIZE[15:8];
        endcase
        return v;
    endfunction

endpackage

// ----- sv/rls_in_if.sv -----
`timescale 1ns / 1ps

interface rls_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] flash_byte;
    logic       restart;

    modport source (output valid, output flash_byte, output restart, input ready);
    modport sink   (input valid, input flash_byte, input restart, output ready);
endinterface

// ----- sv/rls_out_if.sv -----
`timescale 1ns / 1ps

interface rls_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_status;
    logic        scan_done;
    logic        found_any;
    logic [6:0]  volume_out;
    logic [7:0]  theme_out;
    logic [12:0] next_offset;
    logic        compact_needed;

    modport source (output valid, output record_status, output scan_done, output found_any,
                    output volume_out, output theme_out, output next_offset,
                    output compact_needed, input ready);
    modport sink   (input valid, input record_status, input scan_done, input found_any,
                    input volume_out, input theme_out, input next_offset,
                    input compact_needed, output ready);
endinterface

// ----- sv/settings_record_log_scanner.sv -----
`timescale 1ns / 1ps

// channel    dir  handshake      payload
// byte_in    in   valid/ready    flash_byte[7:0], restart
// result     out  valid/ready    record_status, scan_done, found_any, volume_out,
//                                theme_out, next_offset[12:0], compact_needed
// cfg        in   cfg_we         cfg_index[0], cfg_data[7:0] (write only)
//
// one byte per cycle sustained; a result is registered in the result register once
// the byte input register has passed on the sixteenth byte of a record
// the byte input register and the result register form the two stages; the
// per-byte crc step is one unrolled byte-wide xor network
// rst_n clears all control state asynchronously; defaults return to 50 and 0
// a stalled result holds the pipeline; bytes that give no result keep flowing
// while the result register is empty or being drained

module settings_record_log_scanner (
    input  logic                            clk,
    input  logic                            rst_n,
    rls_in_if.sink                          byte_in,
    rls_out_if.source                       result,
    input  logic                            cfg_we,
    input  logic [rls_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rls_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rls_pkg::*;

    // configuration registers
    logic [6:0] def_vol_reg;
    logic [7:0] def_theme_reg;

    // input register stage
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_restart_reg;

    // scan state
    logic [OFS_W-1:0] ofs_reg, ofs_next;
    logic [6:0]       cur_vol_reg, cur_vol_next;
    logic [7:0]       cur_theme_reg, cur_theme_next;
    logic             found_reg, found_next;
    logic             compact_reg, compact_next;
    logic             done_reg, done_next;

    // result register
    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg, out_status_next;
    logic [OFS_W-1:0] out_ofs_reg, out_ofs_next;
    logic             out_done_reg, out_found_reg, out_compact_reg;
    logic [6:0]       out_vol_reg;
    logic [7:0]       out_theme_reg;

    logic             advance;
    logic             process;
    logic             step;
    logic             emit;
    logic [OFS_W-1:0] ofs_eff, ofs_plus;
    logic             sector_full;
    logic [31:0]      ofs_wide;
    rec_info_t        info;

    // result register is free or is being drained this cycle
    assign advance       = !out_valid_reg || result.ready;
    assign process       = s1_valid_reg && advance;
    assign byte_in.ready = !s1_valid_reg || advance;

    // bytes after the end of a scan are dropped until a restart
    assign step = process && (s1_restart_reg || !done_reg);
    assign emit = step && info.last;

    rls_record_acc u_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .clear      (s1_restart_reg),
        .flash_byte (s1_byte_reg),
        .info       (info)
    );

    assign ofs_eff     = s1_restart_reg ? '0 : ofs_reg;
    assign ofs_plus    = ofs_eff + OFS_W'(REC_SIZE);
    assign sector_full = (ofs_plus >= OFS_W'(SECTOR_BYTES));

    always_comb
    begin
        s1_valid_next   = s1_valid_reg;
        ofs_next        = ofs_reg;
        cur_vol_next    = cur_vol_reg;
        cur_theme_next  = cur_theme_reg;
        found_next      = found_reg;
        compact_next    = compact_reg;
        done_next       = done_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_ofs_next    = out_ofs_reg;

        if (advance)
        begin
            out_valid_next = 1'b0;
        end
        if (byte_in.ready)
        begin
            s1_valid_next = byte_in.valid;
        end

        if (process && s1_restart_reg)
        begin
            // restart picks up whatever defaults stand now
            ofs_next       = '0;
            cur_vol_next   = def_vol_reg;
            cur_theme_next = def_theme_reg;
            found_next     = 1'b0;
            compact_next   = 1'b0;
            done_next      = 1'b0;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            if (info.erased)
            begin
                out_status_next = ST_ERASED;
                done_next       = 1'b1;
                ofs_next        = ofs_eff;
            end
            else if (!info.good)
            begin
                out_status_next = ST_CORRUPT;
                done_next       = 1'b1;
                compact_next    = 1'b1;
                ofs_next        = ofs_eff;
            end
            else
            begin
                cur_vol_next   = info.vol_byte[6:0];
                cur_theme_next = (info.theme_byte == ERASED_BYTE) ? def_theme_reg
                                                                  : info.theme_byte;
                found_next     = 1'b1;
                ofs_next       = ofs_plus;
                if (sector_full)
                begin
                    out_status_next = ST_FULL;
                    done_next       = 1'b1;
                    compact_next    = 1'b1;
                end
                else
                begin
                    out_status_next = ST_VALID;
                end
            end
            out_ofs_next = ofs_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_vol_reg    <= DEFAULT_VOLUME_RST;
            def_theme_reg  <= DEFAULT_THEME_RST;
            s1_valid_reg   <= 1'b0;
            ofs_reg        <= '0;
            cur_vol_reg    <= DEFAULT_VOLUME_RST;
            cur_theme_reg  <= DEFAULT_THEME_RST;
            found_reg      <= 1'b0;
            compact_reg    <= 1'b0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEFAULT_VOLUME: def_vol_reg   <= cfg_data[6:0];
                    REG_DEFAULT_THEME:  def_theme_reg <= cfg_data;
                    default:            ;
                endcase
            end
            s1_valid_reg  <= s1_valid_next;
            ofs_reg       <= ofs_next;
            cur_vol_reg   <= cur_vol_next;
            cur_theme_reg <= cur_theme_next;
            found_reg     <= found_next;
            compact_reg   <= compact_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (byte_in.ready && byte_in.valid)
        begin
            s1_byte_reg    <= byte_in.flash_byte;
            s1_restart_reg <= byte_in.restart;
        end
        out_status_reg <= out_status_next;
        out_ofs_reg    <= out_ofs_next;
        if (emit)
        begin
            out_done_reg    <= done_next;
            out_found_reg   <= found_next;
            out_vol_reg     <= cur_vol_next;
            out_theme_reg   <= cur_theme_next;
            out_compact_reg <= compact_next;
        end
    end

    // result field keeps the low bits of the offset
    assign ofs_wide = 32'(out_ofs_reg);

    assign result.valid          = out_valid_reg;
    assign result.record_status  = out_status_reg;
    assign result.scan_done      = out_done_reg;
    assign result.found_any      = out_found_reg;
    assign result.volume_out     = out_vol_reg;
    assign result.theme_out      = out_theme_reg;
    assign result.next_offset    = ofs_wide[OUT_OFS_W-1:0];
    assign result.compact_needed = out_compact_reg;

endmodule

// ----- sv/rls_record_acc.sv -----
`timescale 1ns / 1ps

module rls_record_acc (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              clear,
    input  logic [7:0]        flash_byte,
    output rls_pkg::rec_info_t info
);
    import rls_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next, idx_eff;
    logic [31:0]      crc_reg, crc_next, crc_eff, crc_upd;
    logic             hdr_reg, hdr_next, hdr_eff, hdr_upd;
    logic             erased_reg, erased_next, erased_eff, erased_upd;
    logic [31:0]      stored_reg, stored_next, stored_eff, stored_upd;
    logic [7:0]       vol_reg, vol_next, vol_eff, vol_upd;
    logic [7:0]       theme_reg, theme_next, theme_eff, theme_upd;
    logic             last;

    // a restart byte sees freshly cleared accumulators
    always_comb
    begin
        idx_eff    = clear ? '0 : idx_reg;
        crc_eff    = clear ? CRC_INIT : crc_reg;
        hdr_eff    = clear ? 1'b1 : hdr_reg;
        erased_eff = clear ? 1'b1 : erased_reg;
        stored_eff = clear ? '0 : stored_reg;
        vol_eff    = clear ? '0 : vol_reg;
        theme_eff  = clear ? '0 : theme_reg;
    end

    always_comb
    begin
        erased_upd = erased_eff & (flash_byte == ERASED_BYTE);
        crc_upd    = (idx_eff < CRC_BYTES) ? crc_byte(crc_eff, flash_byte) : crc_eff;
        hdr_upd    = hdr_eff;
        vol_upd    = vol_eff;
        theme_upd  = theme_eff;
        stored_upd = stored_eff;
        if (idx_eff < HDR_BYTES)
        begin
            hdr_upd = hdr_eff & (flash_byte == header_byte(idx_eff[2:0]));
        end
        else if (idx_eff == VOL_POS)
        begin
            vol_upd = flash_byte;
            hdr_upd = hdr_eff & (flash_byte <= VOLUME_MAX);
        end
        else if (idx_eff == THEME_POS)
        begin
            theme_upd = flash_byte;
        end
        else if (idx_eff >= CRC_BYTES)
        begin
            case (idx_eff[1:0])
                2'd0:    stored_upd[7:0]   = flash_byte;
                2'd1:    stored_upd[15:8]  = flash_byte;
                2'd2:    stored_upd[23:16] = flash_byte;
                default: stored_upd[31:24] = flash_byte;
            endcase
        end
        last = (idx_eff == LAST_POS);
    end

    assign info.last       = last;
    assign info.erased     = erased_upd;
    assign info.good       = hdr_upd && (stored_upd == ~crc_upd);
    assign info.vol_byte   = vol_upd;
    assign info.theme_byte = theme_upd;

    always_comb
    begin
        idx_next    = idx_reg;
        crc_next    = crc_reg;
        hdr_next    = hdr_reg;
        erased_next = erased_reg;
        stored_next = stored_reg;
        vol_next    = vol_reg;
        theme_next  = theme_reg;
        if (step)
        begin
            if (last)
            begin
                idx_next    = '0;
                crc_next    = CRC_INIT;
                hdr_next    = 1'b1;
                erased_next = 1'b1;
                stored_next = '0;
                vol_next    = '0;
                theme_next  = '0;
            end
            else
            begin
                idx_next    = idx_eff + 1'b1;
                crc_next    = crc_upd;
                hdr_next    = hdr_upd;
                erased_next = erased_upd;
                stored_next = stored_upd;
                vol_next    = vol_upd;
                theme_next  = theme_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            crc_reg    <= CRC_INIT;
            hdr_reg    <= 1'b1;
            erased_reg <= 1'b1;
            stored_reg <= '0;
            vol_reg    <= '0;
            theme_reg  <= '0;
        end
        else
        begin
            idx_reg    <= idx_next;
            crc_reg    <= crc_next;
            hdr_reg    <= hdr_next;
            erased_reg <= erased_next;
            stored_reg <= stored_next;
            vol_reg    <= vol_next;
            theme_reg  <= theme_next;
        end
    end

endmodule
